[rtl/rpn_stack_evaluator_core_defines.svh]
// assertion macros for the bound checker file
`ifndef RPN_STACK_EVALUATOR_CORE_DEFINES_SVH
`define RPN_STACK_EVALUATOR_CORE_DEFINES_SVH

// same-cycle implication, off while reset is high
`define RPN_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rpn check failed");

// next-cycle implication, off while reset is high
`define RPN_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rpn check failed");

// next-cycle implication that also holds through reset
`define RPN_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("rpn check failed");

`endif

[rtl/rpn_pkg.sv]
package rpn_pkg;

   // data and field widths
   localparam int DATA_W          = 32;
   localparam int OPC_W           = 4;
   localparam int CNT_W           = 7;
   localparam int ST_W            = 3;
   localparam int STACK_DEPTH_DEF = 64;

   // opcodes
   localparam logic [OPC_W-1:0] OP_PUSH = 4'd0;
   localparam logic [OPC_W-1:0] OP_ADD  = 4'd1;
   localparam logic [OPC_W-1:0] OP_SUB  = 4'd2;
   localparam logic [OPC_W-1:0] OP_MUL  = 4'd3;
   localparam logic [OPC_W-1:0] OP_DIV  = 4'd4;
   localparam logic [OPC_W-1:0] OP_MIN  = 4'd5;
   localparam logic [OPC_W-1:0] OP_MAX  = 4'd6;
   localparam logic [OPC_W-1:0] OP_NEG  = 4'd7;
   localparam logic [OPC_W-1:0] OP_IF   = 4'd8;
   localparam logic [OPC_W-1:0] OP_END  = 4'd9;

   // status codes
   localparam logic [ST_W-1:0] ST_OK       = 3'd0;
   localparam logic [ST_W-1:0] ST_DIVZERO  = 3'd1;
   localparam logic [ST_W-1:0] ST_UNDER    = 3'd2;
   localparam logic [ST_W-1:0] ST_OVER     = 3'd3;
   localparam logic [ST_W-1:0] ST_LEFTOVER = 3'd4;

   // divider request and response
   typedef struct packed {
      logic              start;
      logic [DATA_W-1:0] dividend;
      logic [DATA_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [DATA_W-1:0] quotient;
   } div_rsp_type;

endpackage

[rtl/rpn_ram.sv]
module rpn_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/rpn_div.sv]
module rpn_div import rpn_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   localparam int STEP_W = $clog2(DATA_W);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [DATA_W-1:0] rem_ff, rem_in;
   logic [DATA_W-1:0] quo_ff, quo_in;
   logic [DATA_W-1:0] dvs_ff, dvs_in;
   logic              neg_ff, neg_in;
   logic [DATA_W:0]   rem_sh;
   logic [DATA_W:0]   diff;

   // restoring division on magnitudes, one quotient bit per cycle
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      neg_in  = neg_ff;
      rem_sh  = {rem_ff, quo_ff[DATA_W-1]};
      diff    = rem_sh - {1'b0, dvs_ff};
      if (div_req.start) begin
         busy_in = 1'b1;
         step_in = STEP_W'(DATA_W - 1);
         rem_in  = '0;
         quo_in  = div_req.dividend[DATA_W-1] ? (~div_req.dividend + 1'b1)
                                              : div_req.dividend;
         dvs_in  = div_req.divisor[DATA_W-1] ? (~div_req.divisor + 1'b1)
                                             : div_req.divisor;
         neg_in  = div_req.dividend[DATA_W-1] ^ div_req.divisor[DATA_W-1];
      end else if (busy_ff) begin
         if (!diff[DATA_W]) begin
            rem_in = diff[DATA_W-1:0];
            quo_in = {quo_ff[DATA_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[DATA_W-1:0];
            quo_in = {quo_ff[DATA_W-2:0], 1'b0};
         end
         step_in = step_ff - 1'b1;
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dvs_ff  <= dvs_in;
      neg_ff  <= neg_in;
   end

   // sign fix of the quotient, wraps for the most negative value
   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = neg_ff ? (~quo_ff + 1'b1) : quo_ff;

endmodule

[rtl/rpn_stack_evaluator_core.sv]
// channel   direction  handshake            payload
// req       in         req_valid/req_stall  req_opcode, req_number, req_arg_count
// rsp       out        rsp_valid/rsp_stall  rsp_value, rsp_status
//
// one token at a time; req_stall is high from the transfer until the token is done
// push writes in the check state; add/sub/mul/neg/if fetch their operands, then write back
// div waits on the 32-step divider before it writes back; min/max fetch arg_count operands
// operands stream out of the stack memory one per cycle through its single read port
// synchronous reset clears pointer, error and handshake state; no clearing pass
// a waiting result holds in the output register; only the next end waits for it
module rpn_stack_evaluator_core import rpn_pkg::*; #(
   parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [OPC_W-1:0]         req_opcode,
   input  logic signed [DATA_W-1:0] req_number,
   input  logic [CNT_W-1:0]         req_arg_count,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [DATA_W-1:0] rsp_value,
   output logic [ST_W-1:0]          rsp_status
);

   localparam int AW   = $clog2(STACK_DEPTH);
   localparam int SPW  = $clog2(STACK_DEPTH + 1);
   localparam int CMPW = (SPW > CNT_W) ? SPW : CNT_W;
   localparam logic [SPW-1:0] SP_FULL = SPW'(STACK_DEPTH);

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_CHECK = 6'b000010,
      S_FETCH = 6'b000100,
      S_EXEC  = 6'b001000,
      S_DIV   = 6'b010000,
      S_END   = 6'b100000
   } state_type;

   state_type                state_ff, state_in;
   logic [OPC_W-1:0]         op_ff, op_in;
   logic [DATA_W-1:0]        num_ff, num_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic [SPW-1:0]           sp_ff, sp_in;
   logic [ST_W-1:0]          err_ff, err_in;
   logic [SPW-1:0]           need_ff, need_in;
   logic [SPW-1:0]           issued_ff, issued_in;
   logic [SPW-1:0]           recv_ff, recv_in;
   logic                     pend_ff, pend_in;
   logic [DATA_W-1:0]        top_ff, top_in;
   logic [DATA_W-1:0]        sec_ff, sec_in;
   logic [DATA_W-1:0]        thr_ff, thr_in;
   logic [DATA_W-1:0]        best_ff, best_in;
   logic [ST_W-1:0]          end_st_ff, end_st_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] rsp_value_ff, rsp_value_in;
   logic [ST_W-1:0]          rsp_status_ff, rsp_status_in;

   logic [CMPW-1:0]   need_cmp;
   logic [SPW-1:0]    rd_ptr;
   logic [SPW-1:0]    wr_ptr;
   logic [SPW-1:0]    sp_after;
   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [DATA_W-1:0] wr_data;
   logic              rd_en;
   logic [DATA_W-1:0] rd_data;
   div_req_type       div_req;
   div_rsp_type       div_rsp;

   // operand stack storage
   rpn_ram #(
      .WIDTH (DATA_W),
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_ptr[AW-1:0]),
      .rd_data (rd_data)
   );

   // sequential divider used by div
   rpn_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // operands each opcode pops
   always_comb begin
      unique case (op_ff)
         OP_ADD, OP_SUB, OP_MUL, OP_DIV: need_cmp = CMPW'(2);
         OP_NEG, OP_END:                 need_cmp = CMPW'(1);
         OP_IF:                          need_cmp = CMPW'(3);
         OP_MIN, OP_MAX:                 need_cmp = CMPW'(cnt_ff);
         default:                        need_cmp = '0;
      endcase
   end

   // stack addresses: next read walks down from the top, result lands at the deepest pop
   assign rd_ptr   = sp_ff - SPW'(1) - issued_ff;
   assign wr_ptr   = sp_ff - need_ff;
   assign sp_after = wr_ptr + SPW'(1);

   // token sequencer
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      num_in        = num_ff;
      cnt_in        = cnt_ff;
      sp_in         = sp_ff;
      err_in        = err_ff;
      need_in       = need_ff;
      issued_in     = issued_ff;
      recv_in       = recv_ff;
      pend_in       = 1'b0;
      top_in        = top_ff;
      sec_in        = sec_ff;
      thr_in        = thr_ff;
      best_in       = best_ff;
      end_st_in     = end_st_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      wr_en         = 1'b0;
      wr_addr       = wr_ptr[AW-1:0];
      wr_data       = '0;
      rd_en         = 1'b0;
      div_req       = '0;

      // result register drains on a transfer
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in    = req_opcode;
               num_in   = req_number;
               cnt_in   = req_arg_count;
               state_in = S_CHECK;
            end
         end

         S_CHECK: begin
            issued_in = '0;
            recv_in   = '0;
            state_in  = S_IDLE;
            if (op_ff == OP_END) begin
               if (err_ff != ST_OK) begin
                  end_st_in = err_ff;
               end else if (sp_ff == '0) begin
                  end_st_in = ST_UNDER;
               end else if (sp_ff != SPW'(1)) begin
                  end_st_in = ST_LEFTOVER;
               end else begin
                  end_st_in = ST_OK;
               end
               if (err_ff == ST_OK && sp_ff == SPW'(1)) begin
                  need_in  = SPW'(1);
                  state_in = S_FETCH;
               end else begin
                  state_in = S_END;
               end
            end else if (err_ff != ST_OK || op_ff > OP_END) begin
               state_in = S_IDLE;
            end else if (op_ff == OP_PUSH) begin
               if (sp_ff == SP_FULL) begin
                  err_in = ST_OVER;
               end else begin
                  wr_en   = 1'b1;
                  wr_addr = sp_ff[AW-1:0];
                  wr_data = num_ff;
                  sp_in   = sp_ff + SPW'(1);
               end
            end else if (need_cmp == '0 || need_cmp > CMPW'(sp_ff)) begin
               err_in = ST_UNDER;
            end else begin
               need_in  = need_cmp[SPW-1:0];
               state_in = S_FETCH;
            end
         end

         S_FETCH: begin
            // one read issued per cycle, data caught in the cycle after
            if (issued_ff < need_ff) begin
               rd_en     = 1'b1;
               issued_in = issued_ff + SPW'(1);
               pend_in   = 1'b1;
            end
            if (pend_ff) begin
               recv_in = recv_ff + SPW'(1);
               if (recv_ff == '0) begin
                  top_in  = rd_data;
                  best_in = rd_data;
               end else if (op_ff == OP_MIN) begin
                  if ($signed(rd_data) < $signed(best_ff)) begin
                     best_in = rd_data;
                  end
               end else if ($signed(rd_data) > $signed(best_ff)) begin
                  best_in = rd_data;
               end
               if (recv_ff == SPW'(1)) begin
                  sec_in = rd_data;
               end
               if (recv_ff == SPW'(2)) begin
                  thr_in = rd_data;
               end
               if (recv_ff + SPW'(1) == need_ff) begin
                  state_in = S_EXEC;
               end
            end
         end

         S_EXEC: begin
            state_in = S_IDLE;
            wr_en    = 1'b1;
            sp_in    = sp_after;
            unique case (op_ff)
               OP_ADD: wr_data = sec_ff + top_ff;
               OP_SUB: wr_data = sec_ff - top_ff;
               OP_MUL: wr_data = sec_ff * top_ff;
               OP_NEG: wr_data = '0 - top_ff;
               OP_IF:  wr_data = ($signed(thr_ff) > 0) ? sec_ff : top_ff;
               OP_MIN, OP_MAX: wr_data = best_ff;
               OP_DIV: begin
                  wr_en = 1'b0;
                  sp_in = sp_ff;
                  if (top_ff == '0) begin
                     err_in = ST_DIVZERO;
                  end else begin
                     div_req.start    = 1'b1;
                     div_req.dividend = sec_ff;
                     div_req.divisor  = top_ff;
                     state_in         = S_DIV;
                  end
               end
               OP_END: begin
                  wr_en    = 1'b0;
                  sp_in    = sp_ff;
                  state_in = S_END;
               end
               default: begin
                  wr_en = 1'b0;
                  sp_in = sp_ff;
               end
            endcase
         end

         S_DIV: begin
            if (div_rsp.done) begin
               wr_en    = 1'b1;
               wr_data  = div_rsp.quotient;
               sp_in    = sp_after;
               state_in = S_IDLE;
            end
         end

         S_END: begin
            // load the result once the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = (end_st_ff == ST_OK) ? $signed(top_ff) : '0;
               rsp_status_in = end_st_ff;
               sp_in         = '0;
               err_in        = ST_OK;
               state_in      = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         sp_ff        <= '0;
         err_ff       <= ST_OK;
         pend_ff      <= 1'b0;
         issued_ff    <= '0;
         recv_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sp_ff        <= sp_in;
         err_ff       <= err_in;
         pend_ff      <= pend_in;
         issued_ff    <= issued_in;
         recv_ff      <= recv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      num_ff        <= num_in;
      cnt_ff        <= cnt_in;
      need_ff       <= need_in;
      top_ff        <= top_in;
      sec_ff        <= sec_in;
      thr_ff        <= thr_in;
      best_ff       <= best_in;
      end_st_ff     <= end_st_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   // port drive
   assign req_stall  = (state_ff != S_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_status = rsp_status_ff;

endmodule

[rtl/rpn_checker.sv]
`include "rpn_stack_evaluator_core_defines.svh"

module rpn_checker import rpn_pkg::*; (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_stall,
   input logic                     rsp_valid,
   input logic                     rsp_stall,
   input logic signed [DATA_W-1:0] rsp_value,
   input logic [ST_W-1:0]          rsp_status
);

   // a stalled result stays offered
   `RPN_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)

   // a stalled result keeps its payload
   `RPN_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall, $stable(rsp_value) && $stable(rsp_status))

   // an error result carries a zero value
   `RPN_ASSERT_SAME(a_err_zero, clock, reset, rsp_valid && rsp_status != ST_OK, rsp_value == '0)

   // a token transfer makes the block busy the next cycle
   `RPN_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && !req_stall, req_stall)

   // reset leaves no result offered
   `RPN_ASSERT_NEXT_ALWAYS(a_reset_quiet, clock, reset, !rsp_valid)

endmodule

bind rpn_stack_evaluator_core rpn_checker u_rpn_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_valid),
   .req_stall  (req_stall),
   .rsp_valid  (rsp_valid),
   .rsp_stall  (rsp_stall),
   .rsp_value  (rsp_value),
   .rsp_status (rsp_status)
);

[tb/sv/rpn_stack_evaluator_checker.sv]
module rpn_stack_evaluator_checker
   import rpn_pkg::*;
#(
   parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_stall,
   input  logic [OPC_W-1:0]         req_opcode,
   input  logic signed [DATA_W-1:0] req_number,
   input  logic [CNT_W-1:0]         req_arg_count,
   input  logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  logic signed [DATA_W-1:0] rsp_value,
   input  logic [ST_W-1:0]          rsp_status,
   output int                       fail_count,
   output int                       pending_count,
   output int                       result_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [DATA_W-1:0] value;
      logic [ST_W-1:0]   status;
   } outcome_type;

   // shadow copy of the operand stack and evaluator state
   logic [DATA_W-1:0] operands [STACK_DEPTH];
   int                depth;
   logic [ST_W-1:0]   first_error;

   outcome_type outcome_q[$];
   outcome_type oldest;
   int          mismatches;
   int          compared;

   // apply one token to the shadow state, queue a result on end
   task automatic evaluate_token(input logic [OPC_W-1:0]  op,
                                 input logic [DATA_W-1:0] num,
                                 input logic [CNT_W-1:0]  cnt);
      logic [DATA_W-1:0] x, y, r, best, v, a, b, c;
      longint            wide_quotient;
      outcome_type       res;
      int                k;
      if (op == OP_END) begin
         res.value = '0;
         if (first_error != ST_OK) res.status = first_error;
         else if (depth == 0) res.status = ST_UNDER;
         else if (depth > 1) res.status = ST_LEFTOVER;
         else begin
            res.status = ST_OK;
            res.value  = operands[0];
         end
         outcome_q.push_back(res);
         depth       = 0;
         first_error = ST_OK;
      end else if (first_error == ST_OK && op < OP_END) begin
         case (op)
            OP_PUSH: begin
               if (depth >= STACK_DEPTH) first_error = ST_OVER;
               else begin
                  operands[depth] = num;
                  depth++;
               end
            end
            OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
               if (depth < 2) first_error = ST_UNDER;
               else begin
                  x = operands[depth-2];
                  y = operands[depth-1];
                  if (op == OP_DIV && y == '0) first_error = ST_DIVZERO;
                  else begin
                     case (op)
                        OP_ADD: r = x + y;
                        OP_SUB: r = x - y;
                        OP_MUL: r = x * y;
                        default: begin
                           // widen so the most negative over minus one wraps cleanly
                           wide_quotient = longint'($signed(x)) / longint'($signed(y));
                           r = wide_quotient[DATA_W-1:0];
                        end
                     endcase
                     operands[depth-2] = r;
                     depth--;
                  end
               end
            end
            OP_MIN, OP_MAX: begin
               if (cnt == '0 || int'(cnt) > depth) first_error = ST_UNDER;
               else begin
                  best = operands[depth-1];
                  for (k = 2; k <= int'(cnt); k++) begin
                     v = operands[depth-k];
                     if (op == OP_MIN ? ($signed(v) < $signed(best))
                                      : ($signed(best) < $signed(v)))
                        best = v;
                  end
                  operands[depth-int'(cnt)] = best;
                  depth = depth - int'(cnt) + 1;
               end
            end
            OP_NEG: begin
               if (depth < 1) first_error = ST_UNDER;
               else operands[depth-1] = '0 - operands[depth-1];
            end
            OP_IF: begin
               if (depth < 3) first_error = ST_UNDER;
               else begin
                  a = operands[depth-3];
                  b = operands[depth-2];
                  c = operands[depth-1];
                  operands[depth-3] = ($signed(a) > 0) ? b : c;
                  depth -= 2;
               end
            end
            default: ;
         endcase
      end
   endtask

   // watch both channels, predict on request transfers, compare on result transfers
   always @(posedge clock) begin
      if (reset) begin
         depth       = 0;
         first_error = ST_OK;
         outcome_q.delete();
      end else begin
         if (req_valid && !req_stall)
            evaluate_token(req_opcode, req_number, req_arg_count);
         if (rsp_valid && !rsp_stall) begin
            if (outcome_q.size() == 0) begin
               $error("result transfer with nothing outstanding: value %0d status %0d",
                      rsp_value, rsp_status);
               mismatches++;
            end else begin
               oldest = outcome_q.pop_front();
               compared++;
               if (rsp_value !== oldest.value) begin
                  $error("rsp_value: expected %0d, actual %0d",
                         $signed(oldest.value), rsp_value);
                  mismatches++;
               end
               if (rsp_status !== oldest.status) begin
                  $error("rsp_status: expected %0d, actual %0d", oldest.status, rsp_status);
                  mismatches++;
               end
            end
         end
      end
      fail_count    <= mismatches;
      pending_count <= outcome_q.size();
      result_count  <= compared;
   end

endmodule

[tb/sv/tb_rpn_stack_evaluator_core.sv]
module tb_rpn_stack_evaluator_core;
   timeunit 1ns;
   timeprecision 1ps;
   import rpn_pkg::*;

   localparam int               DEPTH        = STACK_DEPTH_DEF;
   localparam int               RANDOM_ITEMS = 1050;
   localparam logic [OPC_W-1:0] OP_UNUSED    = 4'hF;

   logic                     clock         = 1'b0;
   logic                     reset         = 1'b1;
   logic                     req_valid     = 1'b0;
   logic                     req_stall;
   logic [OPC_W-1:0]         req_opcode    = OP_PUSH;
   logic signed [DATA_W-1:0] req_number    = '0;
   logic [CNT_W-1:0]         req_arg_count = '0;
   logic                     rsp_valid;
   logic                     rsp_stall     = 1'b0;
   logic signed [DATA_W-1:0] rsp_value;
   logic [ST_W-1:0]          rsp_status;

   int fail_count;
   int pending_count;
   int result_count;

   int tokens_sent;
   int sequences_run;
   int floods_run;
   int random_start;
   int settle_cycles;
   bit quiet = 1'b0;

   logic [OPC_W-1:0] binary_ops [4] = '{OP_ADD, OP_SUB, OP_MUL, OP_DIV};

   rpn_stack_evaluator_core DUT (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_opcode    (req_opcode),
      .req_number    (req_number),
      .req_arg_count (req_arg_count),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_value     (rsp_value),
      .rsp_status    (rsp_status)
   );

   rpn_stack_evaluator_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_opcode    (req_opcode),
      .req_number    (req_number),
      .req_arg_count (req_arg_count),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_value     (rsp_value),
      .rsp_status    (rsp_status),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .result_count  (result_count)
   );

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // random backpressure on the result side
   always @(posedge clock) begin
      rsp_stall <= !quiet && ($urandom_range(0, 99) < 10);
   end

   // hard stop
   initial begin
      #1_000_000;
      $display("end of test: mismatches");
      $finish;
   end

   // one token, held until its transfer
   task automatic send_token(input logic [OPC_W-1:0]  op,
                             input logic [DATA_W-1:0] num,
                             input logic [CNT_W-1:0]  cnt);
      while (!quiet && $urandom_range(0, 99) < 10) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_opcode    <= op;
      req_number    <= num;
      req_arg_count <= cnt;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (op <= OP_END) tokens_sent++;
   endtask

   task automatic send_op(input logic [OPC_W-1:0] op);
      send_token(op, $urandom, CNT_W'($urandom_range(0, 127)));
   endtask

   task automatic send_push(input logic [DATA_W-1:0] num);
      send_token(OP_PUSH, num, CNT_W'($urandom_range(0, 127)));
   endtask

   task automatic send_count(input logic [OPC_W-1:0] op, input int cnt);
      send_token(op, $urandom, CNT_W'(cnt));
   endtask

   // hold off until every outstanding result has come back
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   // operands lean toward small values and the 32-bit corners
   function automatic logic [DATA_W-1:0] pick_operand();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: return DATA_W'($urandom_range(0, 16)) - DATA_W'(8);
         5: begin
            case ($urandom_range(0, 4))
               0: return 32'h8000_0000;
               1: return 32'h7fff_ffff;
               2: return '1;
               3: return '0;
               default: return 32'd1;
            endcase
         end
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [OPC_W-1:0] pick_min_max();
      return $urandom_range(0, 1) ? OP_MIN : OP_MAX;
   endfunction

   // well-formed expression reduced to one value, then end
   task automatic run_expression();
      int depth_now;
      int pick;
      int n;
      depth_now = 0;
      repeat ($urandom_range(1, 20)) begin
         pick = $urandom_range(0, 9);
         if (depth_now < 2 || pick < 4) begin
            if (depth_now == 1 && pick == 0) send_op(OP_NEG);
            else if (depth_now < DEPTH) begin
               send_push(pick_operand());
               depth_now++;
            end
         end else if (pick < 7) begin
            send_op(binary_ops[$urandom_range(0, 3)]);
            depth_now--;
         end else if (pick == 7) begin
            send_op(OP_NEG);
         end else if (pick == 8 && depth_now >= 3) begin
            send_op(OP_IF);
            depth_now -= 2;
         end else begin
            n = $urandom_range(1, depth_now);
            send_count(pick_min_max(), n);
            depth_now = depth_now - n + 1;
         end
      end
      // fold the rest down to a single value
      while (depth_now > 1) begin
         if ($urandom_range(0, 1)) begin
            send_op(binary_ops[$urandom_range(0, 3)]);
            depth_now--;
         end else begin
            send_count(pick_min_max(), depth_now);
            depth_now = 1;
         end
      end
      send_op(OP_END);
   endtask

   // short prefix, then a fault (or a plain end), then tokens that a fault should make ignored
   task automatic run_broken();
      int               depth_now;
      logic [OPC_W-1:0] op;
      depth_now = $urandom_range(0, 4);
      repeat (depth_now) send_push(pick_operand());
      case ($urandom_range(0, 3))
         // plain end: empty, single value or leftovers
         0: ;
         // zero or excessive operand count
         1: send_count(pick_min_max(),
                       $urandom_range(0, 1) ? 0 : $urandom_range(depth_now + 1, 127));
         // divide by zero, or underflow on a short prefix
         2: begin
            send_push('0);
            send_op(OP_DIV);
         end
         // pop more than is held
         default: begin
            if (depth_now == 0) send_op(OP_NEG);
            else if (depth_now < 2) send_op(binary_ops[$urandom_range(0, 3)]);
            else if (depth_now < 3) send_op(OP_IF);
            else send_count(pick_min_max(), depth_now + 1);
         end
      endcase
      repeat ($urandom_range(0, 3)) begin
         op = OPC_W'($urandom_range(0, 15));
         if (op == OP_END) op = OP_MUL;
         send_op(op);
      end
      send_op(OP_END);
   endtask

   // fill the stack, then either reduce it in one go or overflow it
   task automatic run_flood();
      repeat (DEPTH) send_push(pick_operand());
      if ($urandom_range(0, 1)) begin
         send_count(pick_min_max(), DEPTH);
      end else begin
         send_push(pick_operand());
         send_op(binary_ops[$urandom_range(0, 3)]);
      end
      send_op(OP_END);
      floods_run++;
   endtask

   // arbitrary tokens, unused opcodes included
   task automatic run_noise();
      repeat ($urandom_range(1, 6))
         send_token(OPC_W'($urandom_range(0, 15)), $urandom, CNT_W'($urandom_range(0, 127)));
      send_op(OP_END);
   endtask

   // stimulus and verdict
   initial begin
      int pick;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // end on an empty stack
      send_op(OP_END);
      // add overflow, most negative over minus one, negate of most negative, sub, mul
      send_push(32'h7fff_ffff);
      send_push(32'd1);
      send_op(OP_ADD);
      send_push('1);
      send_op(OP_DIV);
      send_op(OP_NEG);
      send_push(32'd3);
      send_op(OP_SUB);
      send_push(32'd2);
      send_op(OP_MUL);
      send_op(OP_END);
      // if with a zero condition, then max and min
      send_push(32'd0);
      send_push(32'd5);
      send_push(32'd6);
      send_op(OP_IF);
      send_push(32'hffff_fffc);
      send_push(32'd9);
      send_count(OP_MAX, 3);
      send_push(32'd2);
      send_count(OP_MIN, 2);
      send_op(OP_END);
      // divide by zero, then an unused opcode
      send_push(32'd1);
      send_push(32'd0);
      send_op(OP_DIV);
      send_op(OP_UNUSED);
      send_op(OP_END);
      drain_results();

      // random sequences, mostly well formed
      random_start = tokens_sent;
      while (tokens_sent - random_start < RANDOM_ITEMS) begin
         quiet = (tokens_sent - random_start >= 400) && (tokens_sent - random_start < 650);
         pick  = $urandom_range(0, 99);
         if (pick < 72) run_expression();
         else if (pick < 84) run_broken();
         else if (pick < 88) run_flood();
         else run_noise();
         sequences_run++;
         if ($urandom_range(0, 29) == 0) drain_results();
      end
      quiet = 1'b0;
      req_valid <= 1'b0;

      // wait for the last results, then let the block settle
      @(posedge clock);
      settle_cycles = 0;
      while (pending_count != 0 && settle_cycles < 20000) begin
         @(posedge clock);
         settle_cycles++;
      end
      repeat (100) @(posedge clock);

      $display("%0d tokens over %0d random sequences (%0d stack floods), %0d results compared",
               tokens_sent, sequences_run, floods_run, result_count);
      $display("covered wraps, all opcodes, underflow, overflow, divide by zero, leftovers");
      if (fail_count == 0 && pending_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

[sim.f]
+incdir+rtl
rtl/rpn_pkg.sv
rtl/rpn_ram.sv
rtl/rpn_div.sv
rtl/rpn_stack_evaluator_core.sv
rtl/rpn_checker.sv
tb/sv/rpn_stack_evaluator_checker.sv
tb/sv/tb_rpn_stack_evaluator_core.sv
